>>> hw/rtl/pel_pkg.sv
// Package for the positional list engine.
// Holds the sizing constants, operation and status codes, and the cell command struct.
// Depends on nothing; every other file imports it.
package pel_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_END   = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_END   = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_SEARCH    = 3'd6
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What the cell row does while the engine is in its execute state.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_INS  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_SRCH = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_REDUCE = 2'd2
  } state_t;

  typedef struct packed {
    act_t               act;
    logic [CNT_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

>>> hw/rtl/pel_if.sv
// Channel interfaces for the positional list engine: one for operations, one for results.
// Depends on pel_pkg for field widths.
interface pel_in_if;
  import pel_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] item_value;
  logic [POS_W-1:0]          position;

  modport source (output valid, kind, item_value, position, input ready);
  modport sink (input valid, kind, item_value, position, output ready);
endinterface

interface pel_out_if;
  import pel_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] removed_value;
  logic                      found;
  logic [ECNT_W-1:0]         element_count;

  modport source (output valid, status, removed_value, found, element_count, input ready);
  modport sink (input valid, status, removed_value, found, element_count, output ready);
endinterface

>>> hw/rtl/pel_cell.sv
// One list slot: holds an entry, shifts toward either neighbor, taps and compares.
// Depends on pel_pkg.
module pel_cell
  import pel_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [IDX_W-1:0]   my_idx,
  input  cmd_t               cmd,
  input  logic [VALUE_W-1:0] left_data,
  input  logic [VALUE_W-1:0] right_data,
  output logic [VALUE_W-1:0] data,
  output logic [VALUE_W-1:0] tap,
  output logic               match
);

  logic [VALUE_W-1:0] data_r, data_nxt;
  logic [VALUE_W-1:0] tap_r, tap_nxt;
  logic               match_r, match_nxt;
  logic [CNT_W-1:0]   slot;

  assign slot = CNT_W'(my_idx);

  always_comb begin
    data_nxt  = data_r;
    tap_nxt   = tap_r;
    match_nxt = match_r;
    if (en) begin
      tap_nxt   = '0;
      match_nxt = 1'b0;
      unique case (cmd.act)
        ACT_INS: begin
          if (slot == cmd.idx) begin
            data_nxt = cmd.value;
          end else if (slot > cmd.idx && slot <= cmd.cnt) begin
            data_nxt = left_data;
          end
        end
        ACT_DEL: begin
          // The list is non-empty here, so cnt - 1 cannot wrap.
          if (slot == cmd.idx) begin
            tap_nxt = data_r;
          end
          if (slot >= cmd.idx && slot < cmd.cnt - CNT_W'(1)) begin
            data_nxt = right_data;
          end
        end
        ACT_SRCH: begin
          match_nxt = (slot < cmd.cnt) && (data_r == cmd.value);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    tap_r   <= tap_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign tap   = tap_r;
  assign match = match_r;

endmodule

>>> hw/rtl/pel_chain.sv
// Row of DEPTH list cells wired to their neighbors, with the tap and match collection.
// Depends on pel_pkg and pel_cell.
module pel_chain
  import pel_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  cmd_t               cmd,
  output logic [VALUE_W-1:0] tap_or,
  output logic               any_match
);

  logic [VALUE_W-1:0] cell_data [DEPTH];
  logic [VALUE_W-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0]   cell_match;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_d;
    logic [VALUE_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    pel_cell u_cell (
      .clk        (clk),
      .en         (en),
      .my_idx     (IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i]),
      .match      (cell_match[i])
    );
  end

  // At most one cell taps on a delete, so an OR collects the removed entry.
  always_comb begin
    tap_or = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tap_or = tap_or | cell_tap[k];
    end
  end

  assign any_match = |cell_match;

endmodule

>>> hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: decode, sequencing and result register.
// Depends on pel_pkg, pel_if and pel_chain.
//
//   channel   dir  beat carries
//   in_ch     in   kind, item_value, position
//   out_ch    out  status, removed_value, found, element_count
//
// Each operation is decoded at accept; in the execute state every cell shifts or compares
// at once, and in the collect cycle (the reduce state) the taps and match flags are gathered.
// The next operation is taken right after the result is loaded, while it waits.
// A stalled result holds the collect cycle until the previous one is taken.
// Reset empties the list at once; entries are never cleared.
module positional_list_engine
  import pel_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  pel_in_if.sink   in_ch,
  pel_out_if.source out_ch
);

  state_t state_r, state_nxt;

  cmd_t             cmd_r, cmd_nxt;
  status_t          stat_r, stat_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [VALUE_W-1:0]   out_removed_r;
  logic                 out_found_r;
  logic [ECNT_W-1:0]    out_count_r;

  logic               accept;
  logic               load_out;
  logic [VALUE_W-1:0] tap_or;
  logic               any_match;

  logic [POS_W-1:0] count_w;
  logic             full;
  logic             empty;
  logic             pos_zero;
  logic             pos_past;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign count_w  = POS_W'(count_r);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pos_zero = (in_ch.position == '0);
  assign pos_past = (in_ch.position > count_w);

  // Decode the beat into a cell command and an early status.
  always_comb begin
    cmd_nxt.act   = ACT_NONE;
    cmd_nxt.idx   = '0;
    cmd_nxt.cnt   = count_r;
    cmd_nxt.value = in_ch.item_value;
    stat_nxt      = ST_OK;
    unique case (in_ch.kind)
      KIND_INS_FRONT: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          cmd_nxt.act = ACT_INS;
        end
      end
      KIND_INS_END: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          cmd_nxt.act = ACT_INS;
          cmd_nxt.idx = count_r;
        end
      end
      KIND_INS_POS: begin
        if (pos_zero) begin
          stat_nxt = ST_BADPOS;
        end else if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          cmd_nxt.act = ACT_INS;
          cmd_nxt.idx = pos_past ? count_r : CNT_W'(in_ch.position - POS_W'(1));
        end
      end
      KIND_DEL_FRONT: begin
        if (empty) begin
          stat_nxt = ST_EMPTY;
        end else begin
          cmd_nxt.act = ACT_DEL;
        end
      end
      KIND_DEL_END: begin
        if (empty) begin
          stat_nxt = ST_EMPTY;
        end else begin
          cmd_nxt.act = ACT_DEL;
          cmd_nxt.idx = count_r - CNT_W'(1);
        end
      end
      KIND_DEL_POS: begin
        if (empty) begin
          stat_nxt = ST_EMPTY;
        end else if (pos_zero) begin
          stat_nxt = ST_BADPOS;
        end else begin
          cmd_nxt.act = ACT_DEL;
          cmd_nxt.idx = (in_ch.position >= count_w) ? count_r - CNT_W'(1)
                                                    : CNT_W'(in_ch.position - POS_W'(1));
        end
      end
      KIND_SEARCH: begin
        if (empty) begin
          stat_nxt = ST_EMPTY;
        end else begin
          cmd_nxt.act = ACT_SRCH;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_nxt;
      stat_r <= stat_nxt;
    end
  end

  pel_chain u_chain (
    .clk       (clk),
    .en        (state_r == S_EXEC),
    .cmd       (cmd_r),
    .tap_or    (tap_or),
    .any_match (any_match)
  );

  assign load_out = (state_r == S_REDUCE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_REDUCE;
        if (cmd_r.act == ACT_INS) begin
          count_nxt = count_r + CNT_W'(1);
        end else if (cmd_r.act == ACT_DEL) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_REDUCE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r  <= stat_r;
      out_removed_r <= (cmd_r.act == ACT_DEL) ? tap_or : '0;
      out_found_r   <= (cmd_r.act == ACT_SRCH) && any_match;
      out_count_r   <= ECNT_W'(count_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.element_count = out_count_r;

endmodule

>>> hw/rtl/pel_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on pel_pkg and positional_list_engine.
module pel_checker
  import pel_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STAT_W-1:0]  out_status,
  input logic [VALUE_W-1:0] out_removed_value,
  input logic               out_found,
  input logic [ECNT_W-1:0]  out_element_count
);

  // A waiting result keeps its removed value and element count until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removed_value)
                                && $stable(out_element_count))
    else $error("result beat changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_element_count <= ECNT_W'(DEPTH))
    else $error("element count above depth");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK && out_removed_value == '0)
    else $error("found flag on a failed or non-search operation");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("operation taken while the previous one is still in work");

endmodule

bind positional_list_engine pel_checker u_pel_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_removed_value (out_ch.removed_value),
  .out_found         (out_ch.found),
  .out_element_count (out_ch.element_count)
);

>>> bench/list_result_checker.sv
`timescale 1ns / 1ps
// Checker for the positional list engine: keeps its own copy of the list, predicts every
// result beat from the operation beats it sees and compares the two field by field.
// Depends on pel_pkg and the channel interfaces in pel_if.
module list_result_checker
  import pel_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pel_in_if    in_ch,
  pel_out_if   out_ch,
  output int   mismatches,
  output int   pending,
  output int   checked,
  output int   full_seen,
  output int   empty_seen
);

  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] removed_value;
    logic                      found;
    logic [ECNT_W-1:0]         element_count;
  } list_reply_t;

  logic signed [VALUE_W-1:0] shadow_list[$];
  list_reply_t               expected_replies[$];

  function automatic status_t shadow_insert(int idx, logic signed [VALUE_W-1:0] v);
    if (shadow_list.size() >= DEPTH) return ST_FULL;
    if (idx > shadow_list.size()) idx = shadow_list.size();
    shadow_list.insert(idx, v);
    return ST_OK;
  endfunction

  // An index past the end removes the last element.
  function automatic status_t shadow_remove(int idx, output logic signed [VALUE_W-1:0] gone);
    gone = '0;
    if (shadow_list.size() == 0) return ST_EMPTY;
    if (idx >= shadow_list.size()) idx = shadow_list.size() - 1;
    gone = shadow_list[idx];
    shadow_list.delete(idx);
    return ST_OK;
  endfunction

  function automatic list_reply_t predict_reply(kind_t kind, logic signed [VALUE_W-1:0] v,
                                                logic [POS_W-1:0] pos);
    list_reply_t r;
    r.status        = ST_OK;
    r.removed_value = '0;
    r.found         = 1'b0;
    case (kind)
      KIND_INS_FRONT: r.status = shadow_insert(0, v);
      KIND_INS_END:   r.status = shadow_insert(shadow_list.size(), v);
      KIND_INS_POS: begin
        // A zero position is rejected before fullness is looked at.
        if (pos == '0) r.status = ST_BADPOS;
        else r.status = shadow_insert(int'(pos) - 1, v);
      end
      KIND_DEL_FRONT: r.status = shadow_remove(0, r.removed_value);
      KIND_DEL_END:   r.status = shadow_remove(shadow_list.size(), r.removed_value);
      KIND_DEL_POS: begin
        // An empty list wins over a bad position.
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else if (pos == '0) r.status = ST_BADPOS;
        else r.status = shadow_remove(int'(pos) - 1, r.removed_value);
      end
      KIND_SEARCH: begin
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else foreach (shadow_list[i]) if (shadow_list[i] == v) r.found = 1'b1;
      end
      default: ;
    endcase
    r.element_count = ECNT_W'(shadow_list.size());
    return r;
  endfunction

  always @(posedge clk) begin
    list_reply_t want;
    if (!rst_n) begin
      shadow_list.delete();
      expected_replies.delete();
    end else begin
      // The result beat always belongs to an earlier operation, so it is retired first.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          $error("result beat arrived with no operation pending");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          checked++;
          if (out_ch.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.removed_value !== want.removed_value) begin
            $error("removed_value mismatch: expected %0d, actual %0d",
                   want.removed_value, out_ch.removed_value);
            mismatches++;
          end
          if (out_ch.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, out_ch.found);
            mismatches++;
          end
          if (out_ch.element_count !== want.element_count) begin
            $error("element_count mismatch: expected %0d, actual %0d",
                   want.element_count, out_ch.element_count);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = predict_reply(kind_t'(in_ch.kind), in_ch.item_value, in_ch.position);
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        expected_replies.push_back(want);
      end
    end
    pending = expected_replies.size();
  end

endmodule

>>> bench/positional_list_engine_tb.sv
`timescale 1ns / 1ps
// Testbench top for the positional list engine: clock, reset, operation stimulus in bursts
// and result back-pressure; all result checking is done by list_result_checker.
// Depends on pel_pkg, pel_if, the engine RTL and list_result_checker.
module positional_list_engine_tb
  import pel_pkg::*;
;

  localparam int RANDOM_OPS   = 1800;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   ops_sent;
  int   burst_left;
  int   stall_left;
  int   mismatches, pending, checked, full_seen, empty_seen;

  pel_in_if  in_ch();
  pel_out_if out_ch();

  positional_list_engine dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  list_result_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked),
    .full_seen (full_seen),
    .empty_seen(empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The result side moves through three modes: always ready, random stalls, long stalls.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      case ((cycle_count / 300) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(2, 24);
        end
      endcase
    end
  end

  // Sends one operation beat; a new burst may open with an idle gap first.
  task automatic issue_op(kind_t kind, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid      <= 1'b0;
        in_ch.item_value <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.item_value <= v;
    in_ch.position   <= pos;
    do @(posedge clk); while (!in_ch.ready);
    ops_sent++;
  endtask

  // Small values dominate so that searches hit and duplicates appear.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2, 3, 4, 5: return VALUE_W'(int'($urandom_range(0, 8)) - 4);
      default:       return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return POS_W'($urandom_range(0, 65535));
      default: return POS_W'($urandom_range(1, DEPTH + 6));
    endcase
  endfunction

  function automatic kind_t pick_kind(phase_t phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      FILL_PHASE: begin
        if (r < 85) return kind_t'($urandom_range(0, 2));
        if (r < 95) return kind_t'($urandom_range(3, 5));
        return KIND_SEARCH;
      end
      DRAIN_PHASE: begin
        if (r < 80) return kind_t'($urandom_range(3, 5));
        if (r < 90) return kind_t'($urandom_range(0, 2));
        return KIND_SEARCH;
      end
      default: return kind_t'($urandom_range(0, 6));
    endcase
  endfunction

  initial begin
    phase_t phase;
    int     phase_len;
    int     done;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_INS_FRONT;
    in_ch.item_value <= '0;
    in_ch.position   <= '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every delete and the search on an empty list, then the position corner cases.
    issue_op(KIND_DEL_FRONT, 0, '0);
    issue_op(KIND_DEL_END, 0, '0);
    issue_op(KIND_DEL_POS, 0, 16'd5);
    issue_op(KIND_DEL_POS, 0, 16'd0);
    issue_op(KIND_SEARCH, 0, '0);
    issue_op(KIND_INS_POS, 32'sd7, 16'd0);
    issue_op(KIND_INS_POS, 32'sh7FFF_FFFF, 16'hFFFF);
    issue_op(KIND_INS_FRONT, 32'sh8000_0000, '0);
    issue_op(KIND_INS_END, -32'sd1, '0);
    issue_op(KIND_INS_POS, 32'sh5555_5555, 16'd2);
    issue_op(KIND_INS_POS, 32'shAAAA_AAAA, 16'd1);
    issue_op(KIND_SEARCH, 32'sh7FFF_FFFF, '0);
    issue_op(KIND_SEARCH, 32'sd12345, '0);
    issue_op(KIND_DEL_POS, 0, 16'd0);
    issue_op(KIND_DEL_POS, 0, 16'hFFFF);
    issue_op(KIND_DEL_POS, 0, 16'd2);
    issue_op(KIND_DEL_FRONT, 0, '0);
    issue_op(KIND_DEL_END, 0, '0);
    issue_op(KIND_DEL_END, 0, '0);
    issue_op(KIND_INS_POS, 32'sd42, 16'd3);
    issue_op(KIND_DEL_POS, 0, 16'd1);

    // Fill phases push the list to full, drain phases empty it again.
    done = 0;
    while (done < RANDOM_OPS) begin
      phase     = phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(40, 160);
      for (int n = 0; n < phase_len && done < RANDOM_OPS; n++) begin
        issue_op(pick_kind(phase), pick_value(), pick_position());
        done++;
      end
    end
    in_ch.valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Covered %0d list operations; %0d results checked,", ops_sent, checked);
    $display("%0d hit a full list and %0d an empty one.", full_seen, empty_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pel_pkg.sv
hw/rtl/pel_if.sv
hw/rtl/pel_cell.sv
hw/rtl/pel_chain.sv
hw/rtl/positional_list_engine.sv
hw/rtl/pel_checker.sv
bench/list_result_checker.sv
bench/positional_list_engine_tb.sv
